>>> src/glob_wildcard_matcher_defines.svh
// ----------------------------------------------------------------------------
// glob_wildcard_matcher_defines.svh
// Assertion macros used by the gwm_scan sequencer.
// ----------------------------------------------------------------------------
`ifndef GLOB_WILDCARD_MATCHER_DEFINES_SVH
`define GLOB_WILDCARD_MATCHER_DEFINES_SVH

// same-cycle implication
`define GWM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define GWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/gwm_pkg.sv
// ----------------------------------------------------------------------------
// gwm_pkg
// Constants, opcodes and the cell control bundle of the glob matcher.
// ----------------------------------------------------------------------------
package gwm_pkg;

  localparam int PATTERN_WORDS = 256;
  localparam int IDX_W = $clog2(PATTERN_WORDS);

  localparam logic [31:0] OP_BASE     = 32'h8000_0000;
  localparam logic [31:0] OP_ANY      = OP_BASE + 32'd1;
  localparam logic [31:0] OP_STAR     = OP_BASE + 32'd2;
  localparam logic [31:0] OP_ALT      = OP_BASE + 32'd3;
  localparam logic [31:0] OP_JMP      = OP_BASE + 32'd4;
  localparam logic [31:0] OP_ANYOF    = OP_BASE + 32'd5;
  localparam logic [31:0] OP_ANYRANGE = OP_BASE + 32'd6;
  localparam logic [31:0] OP_EXIT     = OP_BASE + 32'd7;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_CHAR = 2'd1;
  localparam logic [1:0] ACT_END  = 2'd2;

  typedef struct packed {
    logic             advance;
    logic             load;
    logic             seed;
    logic             cur0_v;
    logic [IDX_W-1:0] cur0_d;
    logic             cur1_v;
    logic [IDX_W-1:0] cur1_d;
    logic             nxt_v;
    logic [IDX_W-1:0] nxt_d;
  } cell_ctl_t;

endpackage

>>> src/gwm_cell.sv
// ----------------------------------------------------------------------------
// gwm_cell
// One position of the active set: current and next bits, shifted toward the
// head on every scan step.
// ----------------------------------------------------------------------------
module gwm_cell import gwm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctl_t        ctl,
  input  logic [IDX_W-1:0] src_idx,
  input  logic             seed_here,
  input  logic             cur_in,
  input  logic             nxt_in,
  output logic             cur,
  output logic             nxt
);

  logic cur_hit;
  logic nxt_hit;

  assign cur_hit = (ctl.cur0_v && ctl.cur0_d == src_idx) ||
                   (ctl.cur1_v && ctl.cur1_d == src_idx);
  assign nxt_hit = ctl.nxt_v && ctl.nxt_d == src_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= seed_here;
      nxt <= 1'b0;
    end else if (ctl.load) begin
      cur <= ctl.seed ? seed_here : nxt;
      nxt <= 1'b0;
    end else if (ctl.advance) begin
      cur <= cur_in | cur_hit;
      nxt <= nxt_in | nxt_hit;
    end
  end

endmodule

>>> src/gwm_store.sv
// ----------------------------------------------------------------------------
// gwm_store
// Pattern word memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module gwm_store import gwm_pkg::*; (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  logic [31:0]      wdata,
  input  logic [IDX_W-1:0] raddr0,
  input  logic [IDX_W-1:0] raddr1,
  output logic [31:0]      rdata0,
  output logic [31:0]      rdata1
);

  logic [31:0] mem [PATTERN_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

>>> src/gwm_scan.sv
// ----------------------------------------------------------------------------
// gwm_scan
// Sequencer: takes input beats, walks the pattern once per character or end
// beat, drives the cell row and produces the match beat.
// ----------------------------------------------------------------------------
`include "glob_wildcard_matcher_defines.svh"

module gwm_scan import gwm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             case_fold,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       action,
  input  logic [7:0]       word_index,
  input  logic [31:0]      pattern_word,
  input  logic [20:0]      subject_char,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             matched,
  input  logic             head,
  output cell_ctl_t        ctl,
  output logic             we,
  output logic [IDX_W-1:0] waddr,
  output logic [31:0]      wdata,
  output logic [IDX_W-1:0] raddr0,
  output logic [IDX_W-1:0] raddr1,
  input  logic [31:0]      rdata0,
  input  logic [31:0]      rdata1
);

  typedef enum logic [2:0] {
    IDLE, RD, EVAL, MRD, MEV, RRD, REV, DONE
  } state_t;

  localparam logic [33:0] N34 = 34'(PATTERN_WORDS);

  state_t           state;
  logic [IDX_W-1:0] pc;
  logic [IDX_W+1:0] mi;
  logic [IDX_W:0]   lim;
  logic             end_ok;
  logic [IDX_W-1:0] anyof_d;
  logic [31:0]      lo;
  logic [20:0]      ch;
  logic             is_end;
  logic             hit;

  logic             accept;
  logic [31:0]      c32;
  logic [33:0]      pc34;
  logic [33:0]      t_off;
  logic [33:0]      t_end;
  logic             pc1_ok;
  logic             pc2_ok;
  logic [IDX_W+1:0] mi_step;
  logic             mi_go;
  logic             match_now;
  logic             fail_now;
  logic             last_pc;

  assign in_ready = (state == IDLE);
  assign accept   = in_valid && in_ready;
  assign c32      = {11'b0, ch};
  assign pc34     = 34'(pc);
  assign t_off    = pc34 + 34'd1 + 34'(rdata1);
  assign t_end    = pc34 + 34'd2 + 34'(rdata1);
  assign pc1_ok   = (pc34 + 34'd1) < N34;
  assign pc2_ok   = (pc34 + 34'd2) < N34;
  assign last_pc  = (pc == IDX_W'(PATTERN_WORDS - 1));

  assign we    = accept && action == ACT_LOAD &&
                 (32'(word_index) < 32'(PATTERN_WORDS));
  assign waddr = IDX_W'(word_index);
  assign wdata = pattern_word;

  always_comb begin
    unique case (state)
      MRD: begin
        raddr0 = mi[IDX_W-1:0];
        raddr1 = IDX_W'(mi + (IDX_W+2)'(1));
      end
      RRD: begin
        raddr0 = IDX_W'(mi + (IDX_W+2)'(2));
        raddr1 = IDX_W'(mi + (IDX_W+2)'(2));
      end
      default: begin
        raddr0 = pc;
        raddr1 = pc + IDX_W'(1);
      end
    endcase
  end

  // member loop outcome
  always_comb begin
    match_now = 1'b0;
    mi_step   = mi + (IDX_W+2)'(1);
    if (state == MEV) begin
      if (rdata0 == OP_ANYRANGE) begin
        mi_step = mi + (IDX_W+2)'(3);
      end else if (rdata0 == c32) begin
        match_now = 1'b1;
      end
    end else if (state == REV) begin
      mi_step = mi + (IDX_W+2)'(3);
      match_now = (c32 >= lo) && (c32 <= rdata0);
    end
  end
  assign mi_go    = (mi_step < (IDX_W+2)'(lim));
  assign fail_now = !match_now && !mi_go &&
                    !(state == MEV && rdata0 == OP_ANYRANGE &&
                      (34'(mi) + 34'd2) < N34);

  always_comb begin
    ctl = '0;
    ctl.seed = is_end;
    priority case (state)
      EVAL: begin
        ctl.advance = 1'b1;
        if (head) begin
          priority case (rdata0)
            OP_ALT: begin
              ctl.cur0_v = pc2_ok;
              ctl.cur0_d = IDX_W'(2);
              ctl.cur1_v = pc1_ok && t_off < N34;
              ctl.cur1_d = IDX_W'(t_off - pc34);
            end
            OP_JMP: begin
              ctl.cur1_v = pc1_ok && t_off < N34;
              ctl.cur1_d = IDX_W'(t_off - pc34);
            end
            OP_STAR: begin
              ctl.cur0_v = pc1_ok;
              ctl.cur0_d = IDX_W'(1);
              ctl.nxt_v  = !is_end;
              ctl.nxt_d  = '0;
            end
            OP_ANY: begin
              ctl.nxt_v = !is_end && pc1_ok;
              ctl.nxt_d = IDX_W'(1);
            end
            OP_ANYOF: begin
              ctl.advance = is_end || !pc1_ok || !pc2_ok ||
                            !((pc34 + 34'd2) < t_end);
            end
            OP_EXIT: begin
            end
            default: begin
              ctl.nxt_v = !is_end && pc1_ok && rdata0 == c32;
              ctl.nxt_d = IDX_W'(1);
            end
          endcase
        end
      end
      MEV, REV: begin
        ctl.advance = match_now || fail_now;
        ctl.nxt_v   = match_now && end_ok;
        ctl.nxt_d   = anyof_d;
      end
      DONE: begin
        ctl.load = !is_end || !out_valid || out_ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      pc        <= '0;
      out_valid <= 1'b0;
      is_end    <= 1'b0;
      hit       <= 1'b0;
    end else begin
      if (state == DONE && ctl.load && is_end) begin
        out_valid <= 1'b1;
        matched   <= hit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept && (action == ACT_CHAR || action == ACT_END)) begin
            state  <= RD;
            pc     <= '0;
            hit    <= 1'b0;
            is_end <= (action == ACT_END);
            ch     <= (case_fold && subject_char >= 21'h41 && subject_char <= 21'h5A)
                      ? subject_char + 21'h20 : subject_char;
          end
        end
        RD: begin
          state <= EVAL;
        end
        EVAL: begin
          if (head && rdata0 == OP_EXIT && is_end) begin
            hit <= 1'b1;
          end
          if (ctl.advance) begin
            pc    <= pc + IDX_W'(1);
            state <= last_pc ? DONE : RD;
          end else begin
            mi      <= (IDX_W+2)'(pc34 + 34'd2);
            lim     <= (t_end < N34) ? (IDX_W+1)'(t_end) : (IDX_W+1)'(PATTERN_WORDS);
            end_ok  <= t_end < N34;
            anyof_d <= IDX_W'(t_end - pc34);
            state   <= MRD;
          end
        end
        MRD: begin
          state <= MEV;
        end
        MEV, REV: begin
          if (ctl.advance) begin
            pc    <= pc + IDX_W'(1);
            state <= last_pc ? DONE : RD;
          end else if (state == MEV && rdata0 == OP_ANYRANGE &&
                       (34'(mi) + 34'd2) < N34) begin
            lo    <= rdata1;
            state <= RRD;
          end else begin
            mi    <= mi_step;
            state <= MRD;
          end
        end
        RRD: begin
          state <= REV;
        end
        DONE: begin
          if (ctl.load) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  `GWM_ASSERT_NEXT(a_busy_after_scan_beat,
    accept && (action == ACT_CHAR || action == ACT_END), !in_ready)
  `GWM_ASSERT_NOW(a_load_after_full_walk, ctl.load, pc == '0)
  `GWM_ASSERT_NOW(a_result_from_done, $rose(out_valid), $past(state == DONE))
  `GWM_ASSERT_NOW(a_no_overrun, ctl.load && is_end, !out_valid || out_ready)

endmodule

>>> src/glob_wildcard_matcher.sv
// ----------------------------------------------------------------------------
// glob_wildcard_matcher
// Glob matcher over compiled pattern words, active set held in a cell row.
//
//   channel  dir  handshake             payload
//   in       in   in_valid / in_ready   action, word_index, pattern_word,
//                                       subject_char
//   out      out  out_valid / out_ready matched
//   cfg      in   cfg_valid / cfg_ready ignore_case
//
// Load beats and ignored actions are taken without leaving IDLE.
// Character and end beats walk every pattern position: each position is read
// (RD) and evaluated (EVAL), each ANYOF member word read (MRD, MEV) and each
// range bound read (RRD, REV); DONE then loads the next set into the cells.
// Reset seeds position zero; the store holds garbage until loaded.
// A pending match beat stalls the end of the next end walk only.
// ----------------------------------------------------------------------------
module glob_wildcard_matcher import gwm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [7:0]  word_index,
  input  logic [31:0] pattern_word,
  input  logic [20:0] subject_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        matched,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        ignore_case
);

  logic             case_fold;
  cell_ctl_t        ctl;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [31:0]      wdata;
  logic [IDX_W-1:0] raddr0;
  logic [IDX_W-1:0] raddr1;
  logic [31:0]      rdata0;
  logic [31:0]      rdata1;
  logic [PATTERN_WORDS-1:0] cur;
  logic [PATTERN_WORDS-1:0] nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      case_fold <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case_fold <= ignore_case;
    end
  end

  gwm_store u_store (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  for (genvar k = 0; k < PATTERN_WORDS; k++) begin : g_cell
    logic cur_in;
    if (k == PATTERN_WORDS - 1) begin : g_top
      assign cur_in = 1'b0;
    end else begin : g_mid
      assign cur_in = cur[k + 1];
    end
    gwm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .src_idx   (IDX_W'((k + 1) % PATTERN_WORDS)),
      .seed_here (k == 0),
      .cur_in    (cur_in),
      .nxt_in    (nxt[(k + 1) % PATTERN_WORDS]),
      .cur       (cur[k]),
      .nxt       (nxt[k])
    );
  end

  gwm_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .case_fold    (case_fold),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .word_index   (word_index),
    .pattern_word (pattern_word),
    .subject_char (subject_char),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .matched      (matched),
    .head         (cur[0]),
    .ctl          (ctl),
    .we           (we),
    .waddr        (waddr),
    .wdata        (wdata),
    .raddr0       (raddr0),
    .raddr1       (raddr1),
    .rdata0       (rdata0),
    .rdata1       (rdata1)
  );

endmodule
